FILE: rtl/chacha20_stream_cipher_defines.svh
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher assertion macros
// Shared property shapes for the cipher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_DEFINES_SVH

// same-cycle implication
`define CC20_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CC20_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 package
// Types, register indexes and the quarter-round helper.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_KEY01   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY23   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY45   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KEY67   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NONCE01 = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NONCE2  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_START   = 3'd6;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  typedef struct packed {
    logic [31:0] plain;
    logic [3:0]  pos;
    logic        need;   // make a new keystream block before this word
    logic [31:0] ctr;
  } cc20_entry_t;

  typedef struct packed {
    logic [3:0]  pos;
    logic [31:0] blk;
  } cc20_front_stat_t;

  typedef struct packed {
    logic [255:0] key;
    logic [95:0]  nonce;
  } cc20_key_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } cc20_quad_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // half of a quarter round: rotations 16/12, or 8/7 when second is set
  function automatic cc20_quad_t qr_half(input cc20_quad_t q, input logic second);
    cc20_quad_t r;
    logic [31:0] dx;
    logic [31:0] bx;
    r   = q;
    r.a = q.a + q.b;
    dx  = q.d ^ r.a;
    r.d = second ? rotl(dx, 8) : rotl(dx, 16);
    r.c = q.c + r.d;
    bx  = q.b ^ r.c;
    r.b = second ? rotl(bx, 7) : rotl(bx, 12);
    return r;
  endfunction

endpackage

FILE: rtl/cc20_in_if.sv
// ----------------------------------------------------------------------------
// ChaCha20 input channel
// Valid/ready channel carrying one plaintext word and the restart flag.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_word;
  logic        restart;

  modport source (output valid, output plain_word, output restart, input ready);
  modport sink   (input valid, input plain_word, input restart, output ready);
endinterface

FILE: rtl/cc20_out_if.sv
// ----------------------------------------------------------------------------
// ChaCha20 output channel
// Valid/ready channel carrying one ciphertext word.
// ----------------------------------------------------------------------------
interface cc20_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;

  modport source (output valid, output cipher_word, input ready);
  modport sink   (input valid, input cipher_word, output ready);
endinterface

FILE: rtl/chacha20_stream_cipher.sv
// Timing: a beat at word position 0 (or with restart) waits for the back end to compute
//   its block (one half quarter-round level per cycle), then goes to the output register.
// Throughput: other beats pass one word per cycle while the output is not stalled; sustained
//   throughput is set by the shared round unit.
// Reset: clears config and control registers, word position and block counter; keystream is undefined
//   until the first block is computed. No clearing pass.
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// Word-serial RFC 8439 ChaCha20: front tags beats, back makes blocks and XORs.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_defines.svh"

module chacha20_stream_cipher
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  cc20_in_if.sink            in_i,
  cc20_out_if.source         out_o
);

  logic [255:0]     key_q;
  logic [95:0]      nonce_q;
  logic [31:0]      start_q;
  cc20_key_t        key_s;
  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  cc20_entry_t      push_entry;
  cc20_entry_t      head;
  cc20_front_stat_t front_stat;
  logic             in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
      start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY01:   key_q[63:0]    <= cfg_data_i;
        CFG_KEY23:   key_q[127:64]  <= cfg_data_i;
        CFG_KEY45:   key_q[191:128] <= cfg_data_i;
        CFG_KEY67:   key_q[255:192] <= cfg_data_i;
        CFG_NONCE01: nonce_q[63:0]  <= cfg_data_i;
        CFG_NONCE2:  nonce_q[95:64] <= cfg_data_i[31:0];
        CFG_START:   start_q        <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  assign key_s.key   = key_q;
  assign key_s.nonce = nonce_q;

  cc20_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .start_ctr_i (start_q),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry),
    .stat_o      (front_stat)
  );

  cc20_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid)
  );

  cc20_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_s),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  assign in_acc = in_i.valid & in_i.ready;

  `CC20_ASSERT_SAME(a_restart_makes_block, clk_i, rst_ni, in_acc && in_i.restart, push_entry.need, "restart beat not tagged for a new block")
  `CC20_ASSERT_NEXT(a_pop_fills_output, clk_i, rst_ni, pop, out_o.valid, "popped word did not reach the output register")
  `CC20_ASSERT_NEXT(a_counter_advances, clk_i, rst_ni, in_acc && push_entry.pos == 4'hF, front_stat.blk == $past(push_entry.ctr) + 32'd1, "block counter did not advance after the last word")

endmodule

FILE: rtl/cc20_fifo.sv
// ----------------------------------------------------------------------------
// ChaCha20 entry queue
// Two-entry first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module cc20_fifo
  import cc20_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cc20_entry_t entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output cc20_entry_t head_o,
  output logic        valid_o
);

  cc20_entry_t mem_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/cc20_front.sv
// ----------------------------------------------------------------------------
// ChaCha20 front end
// Takes input beats, tracks word position and block counter, tags each beat.
// ----------------------------------------------------------------------------
module cc20_front
  import cc20_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  cc20_in_if.sink          in_i,
  input  logic [31:0]      start_ctr_i,
  input  logic             full_i,
  output logic             push_o,
  output cc20_entry_t      entry_o,
  output cc20_front_stat_t stat_o
);

  logic [3:0]  pos_q, pos_d;
  logic [31:0] blk_q, blk_d;
  logic [3:0]  eff_pos;
  logic [31:0] eff_blk;

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  always_comb begin
    eff_pos = in_i.restart ? 4'd0 : pos_q;
    eff_blk = in_i.restart ? start_ctr_i : blk_q;

    entry_o.plain = in_i.plain_word;
    entry_o.pos   = eff_pos;
    entry_o.need  = (eff_pos == 4'd0);
    entry_o.ctr   = eff_blk;

    pos_d = eff_pos + 4'd1;
    blk_d = (eff_pos == 4'hF) ? eff_blk + 32'd1 : eff_blk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      blk_q <= 32'd0;
    end else if (push_o) begin
      pos_q <= pos_d;
      blk_q <= blk_d;
    end
  end

  assign stat_o.pos = pos_q;
  assign stat_o.blk = blk_q;

endmodule

FILE: rtl/cc20_back.sv
// ----------------------------------------------------------------------------
// ChaCha20 back end
// Runs the block function one half quarter-round level per cycle and
// XORs queued words with the keystream into the output register.
// ----------------------------------------------------------------------------
module cc20_back
  import cc20_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cc20_key_t   key_i,
  input  cc20_entry_t head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  cc20_out_if.source  out_o
);

  localparam int unsigned Steps = 4 * DOUBLE_ROUNDS;
  localparam int unsigned StepW = $clog2(Steps);
  localparam logic [StepW-1:0] StepLast = StepW'(Steps - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_ADD   = 3'b100
  } back_state_e;

  back_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;
  logic             oval_q, oval_d;
  logic [31:0]      odata_q;
  logic [31:0]      w_q   [16];
  logic [31:0]      w_nx  [16];
  logic [31:0]      init  [16];
  logic             out_free;
  logic             start_blk;

  assign out_free  = ~oval_q | out_o.ready;
  assign start_blk = (state_q == ST_IDLE) & head_valid_i & head_i.need & ~done_q;
  assign pop_o     = (state_q == ST_IDLE) & head_valid_i & (~head_i.need | done_q) & out_free;

  assign out_o.valid       = oval_q;
  assign out_o.cipher_word = odata_q;

  // block input state; head stays put until its word is popped
  always_comb begin
    init[0]  = SIGMA0;
    init[1]  = SIGMA1;
    init[2]  = SIGMA2;
    init[3]  = SIGMA3;
    for (int k = 0; k < 8; k++) begin
      init[4+k] = key_i.key[32*k +: 32];
    end
    init[12] = head_i.ctr;
    init[13] = key_i.nonce[31:0];
    init[14] = key_i.nonce[63:32];
    init[15] = key_i.nonce[95:64];
  end

  // four quarter rounds in parallel; step bit 1 picks diagonal, bit 0 the half
  always_comb begin
    logic [1:0] o1;
    logic [1:0] o2;
    logic [1:0] o3;
    cc20_quad_t q;
    cc20_quad_t r;
    w_nx = w_q;
    for (int i = 0; i < 4; i++) begin
      o1 = 2'(i) + {1'b0, step_q[1]};
      o2 = 2'(i) + {step_q[1], 1'b0};
      o3 = 2'(i) + {step_q[1], step_q[1]};
      q.a = w_q[i];
      q.b = w_q[{2'b01, o1}];
      q.c = w_q[{2'b10, o2}];
      q.d = w_q[{2'b11, o3}];
      r = qr_half(q, step_q[0]);
      w_nx[i]             = r.a;
      w_nx[{2'b01, o1}]   = r.b;
      w_nx[{2'b10, o2}]   = r.c;
      w_nx[{2'b11, o3}]   = r.d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = done_q;
    oval_d  = oval_q;
    if (pop_o) begin
      oval_d = 1'b1;
      done_d = 1'b0;
    end else if (out_o.ready) begin
      oval_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (start_blk) begin
          step_d  = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        step_d = step_q + 1'b1;
        if (step_q == StepLast) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
      oval_q  <= oval_d;
    end
  end

  // working state doubles as the keystream buffer once the add is done
  always_ff @(posedge clk_i) begin
    if (start_blk) begin
      w_q <= init;
    end else if (state_q == ST_ROUND) begin
      w_q <= w_nx;
    end else if (state_q == ST_ADD) begin
      for (int k = 0; k < 16; k++) begin
        w_q[k] <= w_q[k] + init[k];
      end
    end
    if (pop_o) begin
      odata_q <= head_i.plain ^ w_q[head_i.pos];
    end
  end

endmodule
